>>> sv/psl_pkg.sv
package psl_pkg;

	// Default width of one shifter word.
	localparam int WORD_BITS_DEF = 6;

	// Configuration port widths.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Each accepted step value is placed this many bits up in its word.
	localparam int STEP_SHIFT = 2;

	// Register reset values.
	localparam logic [7:0]  HALF_PERIOD_RESET  = 8'd1;
	localparam logic [15:0] MIN_INTERVAL_RESET = 16'd1000;
	localparam logic [3:0]  MAX_STEPS_RESET    = 4'd15;

	// Saturation point of the tick counter since the last latch.
	localparam logic [15:0] SINCE_MAX = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HALF_PERIOD  = 2'd0,
		CFG_MIN_INTERVAL = 2'd1,
		CFG_MAX_STEPS    = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_BUSY  = 2'd2
	} status_t;

	typedef enum logic [6:0] {
		PH_IDLE     = 7'b0000001,
		PH_WAIT     = 7'b0000010,
		PH_DATA     = 7'b0000100,
		PH_CLKHI    = 7'b0001000,
		PH_CLKLO    = 7'b0010000,
		PH_PRELATCH = 7'b0100000,
		PH_LATCH    = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [7:0]  half_period;
		logic [15:0] min_interval;
		logic [3:0]  max_steps;
	} cfg_t;

	typedef struct packed {
		logic    ser;
		logic    clk;
		logic    latch;
		logic    busy;
		status_t status;
	} res_t;

endpackage

>>> sv/phase_shifter_serial_loader.sv
// Serial loader for a chained pair of phase shifters.
// Input channel (in_valid / in_stall): each item is either a time tick
// (func low) or a write request carrying two step values (func high).
// Output channel (out_valid / out_stall): exactly one result item per input
// item, in order, giving the serial data, clock and latch pin levels after
// that item, whether a load sequence is running, and the write status.
// Configuration channel (cfg_valid / cfg_ready): always ready; registers are
// the half period in ticks, the least ticks between latch rises and the
// largest accepted step value. Write them only while the block is idle.
// An item is captured in the input register, its result is worked out
// from the sequencer state and held in the output register. Throughput is
// one item per cycle while the receiver does not stall, set by the single
// state update in the core.
// When the receiver stalls, the output register holds its item and the input
// register keeps the next one; in_stall rises only once both are full.
// Reset clears the registers to their defaults, sets the core's pin levels
// low and leaves the sequencer idle with no latch yet seen.
module phase_shifter_serial_loader #(
	parameter int WORD_BITS = psl_pkg::WORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            func,
	input  logic [7:0]                      first_channel_steps,
	input  logic [7:0]                      second_channel_steps,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            ser_level,
	output logic                            clk_level,
	output logic                            latch_level,
	output logic                            busy_res,
	output logic [1:0]                      status,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [psl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [psl_pkg::CFG_DATA_W-1:0]  cfg_data
);

	psl_pkg::cfg_t cfg;
	psl_pkg::res_t res;
	psl_pkg::res_t res_s2;

	logic       valid_s1, valid_s2;
	logic       func_s1;
	logic [7:0] ch1_s1, ch2_s1;
	logic       adv, en;

	// The output register can take a new item when it is empty or being read.
	assign adv      = !valid_s2 || !out_stall;
	assign en       = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	assign cfg_ready = 1'b1;

	psl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	psl_core #(
		.WORD_BITS (WORD_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.func   (func_s1),
		.ch1    (ch1_s1),
		.ch2    (ch2_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1 <= func;
			ch1_s1  <= first_channel_steps;
			ch2_s1  <= second_channel_steps;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign ser_level   = res_s2.ser;
	assign clk_level   = res_s2.clk;
	assign latch_level = res_s2.latch;
	assign busy_res    = res_s2.busy;
	assign status      = res_s2.status;

endmodule

>>> sv/psl_cfg.sv
module psl_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [psl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [psl_pkg::CFG_DATA_W-1:0]   cfg_data,
	output psl_pkg::cfg_t                    cfg
);

	psl_pkg::cfg_t cfg_q;

	// Writes to an index beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period  <= psl_pkg::HALF_PERIOD_RESET;
			cfg_q.min_interval <= psl_pkg::MIN_INTERVAL_RESET;
			cfg_q.max_steps    <= psl_pkg::MAX_STEPS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				psl_pkg::CFG_HALF_PERIOD: begin
					cfg_q.half_period <= cfg_data[7:0];
				end
				psl_pkg::CFG_MIN_INTERVAL: begin
					cfg_q.min_interval <= cfg_data[15:0];
				end
				psl_pkg::CFG_MAX_STEPS: begin
					cfg_q.max_steps <= cfg_data[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/psl_core.sv
module psl_core #(
	parameter int WORD_BITS = psl_pkg::WORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          func,
	input  logic [7:0]    ch1,
	input  logic [7:0]    ch2,
	input  psl_pkg::cfg_t cfg,
	output psl_pkg::res_t res
);

	localparam int PAT_W = 2 * WORD_BITS;
	localparam int BIW   = $clog2(PAT_W);
	localparam logic [BIW-1:0] LAST_IDX = BIW'(PAT_W - 1);
	localparam int WIDE_W = WORD_BITS + 8 + psl_pkg::STEP_SHIFT;

	psl_pkg::phase_t ph_q, ph_d;
	logic [BIW-1:0]  bit_q, bit_d, bit_inc, pos_next;
	logic [7:0]      half_q, half_d, limit;
	logic [8:0]      half_inc;
	logic [15:0]     since_q, since_d;
	logic            has_q, has_d;
	logic [PAT_W-1:0] pat_q, pat_d;
	logic            ser_q, ser_d, clk_q, clk_d, le_q, le_d;
	logic            start;
	psl_pkg::status_t status;
	logic [WIDE_W-1:0] wide1, wide2;
	logic [WORD_BITS-1:0] w1, w2;

	// Words are the step values moved up two places and cut to the word width.
	assign wide1 = {{WORD_BITS{1'b0}}, ch1, {psl_pkg::STEP_SHIFT{1'b0}}};
	assign wide2 = {{WORD_BITS{1'b0}}, ch2, {psl_pkg::STEP_SHIFT{1'b0}}};
	assign w1 = wide1[WORD_BITS-1:0];
	assign w2 = wide2[WORD_BITS-1:0];

	assign limit    = (cfg.half_period == 8'd0) ? 8'd1 : cfg.half_period;
	assign half_inc = {1'b0, half_q} + 9'd1;
	assign bit_inc  = bit_q + BIW'(1);
	assign pos_next = LAST_IDX - bit_inc;

	always_comb begin
		ph_d    = ph_q;
		bit_d   = bit_q;
		half_d  = half_q;
		since_d = since_q;
		has_d   = has_q;
		pat_d   = pat_q;
		ser_d   = ser_q;
		clk_d   = clk_q;
		le_d    = le_q;
		status  = psl_pkg::ST_OK;
		start   = 1'b0;

		if (func) begin
			if (ph_q != psl_pkg::PH_IDLE) begin
				status = psl_pkg::ST_BUSY;
			end else if (ch1 > {4'd0, cfg.max_steps} || ch2 > {4'd0, cfg.max_steps}) begin
				status = psl_pkg::ST_RANGE;
			end else begin
				pat_d = {w2, w1};
				if (has_q && since_q < cfg.min_interval) begin
					ph_d   = psl_pkg::PH_WAIT;
					half_d = 8'd0;
				end else begin
					start = 1'b1;
				end
			end
		end else begin
			if (has_q && since_q != psl_pkg::SINCE_MAX) begin
				since_d = since_q + 16'd1;
			end
			case (ph_q)
				psl_pkg::PH_IDLE: begin
				end
				psl_pkg::PH_WAIT: begin
					if (since_d >= cfg.min_interval) begin
						start = 1'b1;
					end
				end
				default: begin
					if (half_inc >= {1'b0, limit}) begin
						half_d = 8'd0;
						case (ph_q)
							psl_pkg::PH_DATA: begin
								clk_d = 1'b1;
								ph_d  = psl_pkg::PH_CLKHI;
							end
							psl_pkg::PH_CLKHI: begin
								clk_d = 1'b0;
								ph_d  = psl_pkg::PH_CLKLO;
							end
							psl_pkg::PH_CLKLO: begin
								if (bit_q != LAST_IDX) begin
									bit_d = bit_inc;
									ser_d = pat_q[pos_next];
									ph_d  = psl_pkg::PH_DATA;
								end else begin
									ph_d = psl_pkg::PH_PRELATCH;
								end
							end
							psl_pkg::PH_PRELATCH: begin
								le_d    = 1'b1;
								since_d = 16'd0;
								has_d   = 1'b1;
								ph_d    = psl_pkg::PH_LATCH;
							end
							default: begin
								le_d  = 1'b0;
								ser_d = 1'b0;
								ph_d  = psl_pkg::PH_IDLE;
							end
						endcase
					end else begin
						half_d = half_inc[7:0];
					end
				end
			endcase
		end

		// Start of the shift: pins low and the first bit of channel 2 on the data line.
		if (start) begin
			le_d   = 1'b0;
			clk_d  = 1'b0;
			bit_d  = '0;
			half_d = 8'd0;
			ser_d  = pat_d[PAT_W-1];
			ph_d   = psl_pkg::PH_DATA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= psl_pkg::PH_IDLE;
			bit_q   <= '0;
			half_q  <= 8'd0;
			since_q <= 16'd0;
			has_q   <= 1'b0;
			pat_q   <= '0;
			ser_q   <= 1'b0;
			clk_q   <= 1'b0;
			le_q    <= 1'b0;
		end else if (en) begin
			ph_q    <= ph_d;
			bit_q   <= bit_d;
			half_q  <= half_d;
			since_q <= since_d;
			has_q   <= has_d;
			pat_q   <= pat_d;
			ser_q   <= ser_d;
			clk_q   <= clk_d;
			le_q    <= le_d;
		end
	end

	assign res.ser    = ser_d;
	assign res.clk    = clk_d;
	assign res.latch  = le_d;
	assign res.busy   = (ph_d != psl_pkg::PH_IDLE);
	assign res.status = status;

endmodule

>>> sv/psl_checker.sv
module psl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        ser_level,
	input logic        clk_level,
	input logic        latch_level,
	input logic        busy_res,
	input logic [1:0]  status
);

	// A stalled result item is held unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({ser_level, clk_level,
			latch_level, busy_res, status}))
		else $error("result item changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == psl_pkg::ST_OK || status == psl_pkg::ST_RANGE ||
			status == psl_pkg::ST_BUSY))
		else $error("undefined status code");

	// The serial clock is only high in the middle of a load sequence.
	a_clk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clk_level |-> busy_res)
		else $error("serial clock high while idle");

	// The latch pulse belongs to the sequence and never overlaps the clock.
	a_latch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && latch_level |-> busy_res && !clk_level)
		else $error("latch high outside its slot");

endmodule

bind phase_shifter_serial_loader psl_checker u_psl_checker (.*);
